// ===== hw/rtl/bfg_pkg.sv =====
// shared types and constants for the battery fuel gauge and source monitor
`default_nettype none
package bfg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROTECT_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CABLE_MIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_BATTERY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_PERCENT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESUME_PERCENT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_MIN        = 3'd7;

  // divider sizing: largest dividend is |i| << 24, largest divisor capacity * 36
  localparam int DIVIDEND_W = 38;
  localparam int DIVISOR_W  = 22;
  localparam int DIV_CNT_W  = 6;

  localparam int LEVEL_W  = 31;
  localparam int PCT_FRAC = 24;
  localparam int EMPTY_MV = 6000;
  localparam int FULL_MV  = 8400;
  localparam int CAP_SCALE   = 36;

  // x / 10 as (x * 52429) >> 19, exact for x below 2^18
  localparam int CUR_RECIP  = 52429;
  localparam int CUR_SHIFT  = 19;
  // x / 3 as (x * 171) >> 9, exact for x below 512
  localparam int SEED_RECIP = 171;
  localparam int SEED_SHIFT = 9;

  typedef enum logic [2:0] {
    SRC_UNKNOWN  = 3'd0,
    SRC_BATTERY  = 3'd1,
    SRC_EXTERNAL = 3'd2,
    SRC_CHARGING = 3'd3,
    SRC_NOBAT    = 3'd4
  } bfg_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRC,
    S_STEP,
    S_UPD,
    S_EMIT
  } bfg_state_t;

  typedef struct packed {
    logic        protect_enable;
    logic [9:0]  current_threshold_ma;
    logic [13:0] cable_min_mv;
    logic [13:0] no_battery_mv;
    logic [15:0] capacity_mah;
    logic [6:0]  cut_percent;
    logic [6:0]  resume_percent;
    logic [13:0] cut_min_mv;
  } bfg_cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic [DIV_CNT_W-1:0]  count;
  } bfg_div_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bfg_config.sv =====
// configuration register file with reset values
`default_nettype none
module bfg_config (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [bfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfg_pkg::CFG_DATA_W-1:0] cfg_data,
  output bfg_pkg::bfg_cfg_t                   cfg
);
  import bfg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protect_enable       <= 1'b1;
      cfg.current_threshold_ma <= 10'd15;
      cfg.cable_min_mv         <= 14'd7900;
      cfg.no_battery_mv        <= 14'd8330;
      cfg.capacity_mah         <= 16'd2000;
      cfg.cut_percent          <= 7'd90;
      cfg.resume_percent       <= 7'd85;
      cfg.cut_min_mv           <= 14'd8200;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROTECT_ENABLE: cfg.protect_enable       <= cfg_data[0];
        REG_CURRENT_THRESH: cfg.current_threshold_ma <= cfg_data[9:0];
        REG_CABLE_MIN:      cfg.cable_min_mv         <= cfg_data[13:0];
        REG_NO_BATTERY:     cfg.no_battery_mv        <= cfg_data[13:0];
        REG_CAPACITY:       cfg.capacity_mah         <= cfg_data[15:0];
        REG_CUT_PERCENT:    cfg.cut_percent          <= cfg_data[6:0];
        REG_RESUME_PERCENT: cfg.resume_percent       <= cfg_data[6:0];
        REG_CUT_MIN:        cfg.cut_min_mv           <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bfg_divider.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module bfg_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  bfg_pkg::bfg_div_req_t               req,
  output logic                                busy,
  output logic [bfg_pkg::DIVIDEND_W-1:0]      quotient
);
  import bfg_pkg::*;

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIVIDEND_W-1:0] dq;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // dividend arrives left-aligned, so after count steps dq holds the quotient
  assign trial    = {rem, dq[DIVIDEND_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = (trial >= {1'b0, divisor});
  assign busy     = (cnt != '0);
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= req.count;
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      dq      <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      dq  <= {dq[DIVIDEND_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/battery_fuel_gauge_source_monitor_top.sv =====
// good sample, level seeded: source decision, level step in the divider, update, then emit;
// with no level to seed or step, the divider step is skipped; a read error goes straight to emit
// one sample in flight; the next transfer is taken once emit has loaded the output register
// a finished result is held in the output register while the next sample is taken
// synchronous active-high reset: config to defaults, level unseeded, sensor unavailable
`default_nettype none
module battery_fuel_gauge_source_monitor_top #(
  parameter int VOTE_LIMIT   = 10,
  parameter int STABLE_VOTES = 5,
  parameter int ERROR_LIMIT  = 3
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [bfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [15:0]                    bus_raw,
  input  wire logic signed [15:0]             current_raw,
  input  wire logic                           read_error,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [16:0]                         meas_mv,
  output logic signed [14:0]                  meas_ma,
  output logic [2:0]                          power_source,
  output logic [6:0]                          level_percent,
  output logic                                level_known,
  output logic                                cutoff_active,
  output logic                                charger_enable,
  output logic                                sensor_available
);
  import bfg_pkg::*;

  localparam int VW = $clog2(VOTE_LIMIT + 1) + 1;
  localparam int EW = $clog2(ERROR_LIMIT + 1);
  localparam logic signed [VW-1:0] VOTE_MAX = VW'(VOTE_LIMIT);
  localparam logic signed [VW-1:0] VOTE_MIN = -VOTE_MAX;
  localparam logic signed [VW-1:0] VOTE_ONE = VW'(1);
  localparam logic signed [8:0]    STABLE   = 9'(STABLE_VOTES);
  localparam logic [EW-1:0]        ERR_MAX  = EW'(ERROR_LIMIT);
  localparam logic signed [34:0]   FULL_Q   = 35'(100) <<< PCT_FRAC;

  bfg_cfg_t     cfg;
  bfg_div_req_t div_req;
  logic         div_busy;
  logic [DIVIDEND_W-1:0] quo;

  bfg_state_t state, state_next;

  // sample state
  logic [EW-1:0]          error_run;
  logic signed [VW-1:0]   external_votes;
  logic signed [VW-1:0]   nobattery_votes;
  bfg_src_t               source_reg;
  logic [LEVEL_W-1:0]     level_fixed;
  logic                   level_seeded;
  logic                   cutoff_reg;
  logic                   available_reg;
  logic [16:0]            voltage_reg;
  logic signed [14:0]     current_reg;
  logic [6:0]             percent_reg;

  bfg_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bfg_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (quo)
  );

  // ---- input conversion
  logic [18:0]     bus_x5;
  logic [16:0]     v_in;
  logic [16:0]     raw_ext;
  logic [16:0]     raw_mag;
  logic [16:0]     raw_x3;
  logic [EW-1:0]   error_run_inc;

  assign bus_x5  = {1'b0, bus_raw, 2'b00} + {3'b000, bus_raw};
  assign v_in    = bus_x5[18:2];
  assign raw_ext = 17'(current_raw);
  assign raw_mag = current_raw[15] ? (17'd0 - raw_ext) : raw_ext;
  assign raw_x3  = 17'(({1'b0, raw_mag} << 1) + {1'b0, raw_mag});
  assign error_run_inc = (error_run < ERR_MAX) ? error_run + EW'(1) : error_run;

  // |raw| * 3 / 10 by reciprocal, sign put back after
  logic [32:0]        cur_prod;
  logic [13:0]        cur_quot;
  logic signed [14:0] cur_in;
  assign cur_prod = 33'(raw_x3) * 33'(CUR_RECIP);
  assign cur_quot = cur_prod[32:CUR_SHIFT];
  assign cur_in   = current_raw[15] ? (15'd0 - {1'b0, cur_quot}) : {1'b0, cur_quot};

  // ---- source decision
  logic signed [15:0] cur_w;
  logic signed [15:0] thr_w;
  logic               is_charging, is_discharging, cable, nobat;
  logic signed [VW-1:0] ext_next, nob_next;
  logic signed [8:0]  ext_w, nob_w;
  bfg_src_t           src_next;

  assign cur_w = 16'(current_reg);
  assign thr_w = signed'({6'b0, cfg.current_threshold_ma});
  assign is_charging    = (cur_w < -thr_w);
  assign is_discharging = (cur_w > thr_w);
  assign cable = (voltage_reg >= {3'b000, cfg.cable_min_mv});
  assign nobat = cable && (voltage_reg >= {3'b000, cfg.no_battery_mv});

  always_comb begin
    if (cable) begin
      ext_next = (external_votes == VOTE_MAX) ? external_votes : external_votes + VOTE_ONE;
    end else begin
      ext_next = (external_votes == VOTE_MIN) ? external_votes : external_votes - VOTE_ONE;
    end
    if (nobat) begin
      nob_next = (nobattery_votes == VOTE_MAX) ? nobattery_votes : nobattery_votes + VOTE_ONE;
    end else begin
      nob_next = (nobattery_votes == VOTE_MIN) ? nobattery_votes : nobattery_votes - VOTE_ONE;
    end
    ext_w = 9'(ext_next);
    nob_w = 9'(nob_next);
    if (is_charging) begin
      src_next = SRC_CHARGING;
    end else if (is_discharging) begin
      src_next = SRC_BATTERY;
    end else if (ext_w >= STABLE) begin
      src_next = (nob_w >= STABLE) ? SRC_NOBAT : SRC_EXTERNAL;
    end else if (ext_w <= -STABLE) begin
      src_next = SRC_BATTERY;
    end else begin
      src_next = source_reg;
    end
  end

  // ---- level seed and step operands
  logic        seed_go;
  logic [11:0] seed_dv;
  logic [8:0]  seed_q;
  logic [15:0] seed_prod;
  logic [6:0]  seed_pct;
  logic [13:0] cur_abs;
  logic [15:0] cap_eff;
  logic [DIVISOR_W-1:0] step_div;

  assign seed_go = !level_seeded && (src_next != SRC_NOBAT) &&
                   (voltage_reg >= 17'(EMPTY_MV)) && (voltage_reg <= 17'(FULL_MV));
  assign seed_dv   = 12'(voltage_reg - 17'(EMPTY_MV));
  // (v - 6000) * 100 / 2400 is (v - 6000) / 24, taken as / 8 then / 3
  assign seed_q    = seed_dv[11:3];
  assign seed_prod = 16'(seed_q) * 16'(SEED_RECIP);
  assign seed_pct  = seed_prod[15:SEED_SHIFT];
  assign cur_abs  = current_reg[14] ? 14'(-current_reg) : current_reg[13:0];
  assign cap_eff  = (cfg.capacity_mah == '0) ? 16'd1 : cfg.capacity_mah;
  assign step_div = 22'(cap_eff) * DIVISOR_W'(CAP_SCALE);

  // ---- step application with clamp to 0..100 percent
  logic signed [34:0]  lvl_w, step_w, lvl_sum;
  logic [LEVEL_W-1:0]  lvl_clamped;
  logic [LEVEL_W-1:0]  lvl_round;

  always_comb begin
    lvl_w  = signed'({4'b0, level_fixed});
    step_w = signed'({2'b0, quo[32:0]});
    // current below zero means charging, so the level rises
    lvl_sum = current_reg[14] ? (lvl_w + step_w) : (lvl_w - step_w);
    if (lvl_sum > FULL_Q) begin
      lvl_clamped = FULL_Q[LEVEL_W-1:0];
    end else if (lvl_sum < 0) begin
      lvl_clamped = '0;
    end else begin
      lvl_clamped = lvl_sum[LEVEL_W-1:0];
    end
    lvl_round = lvl_clamped + (LEVEL_W'(1) << (PCT_FRAC - 1));
  end

  // ---- sequencer
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_req    = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (read_error) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_SRC;
          end
        end
      end
      S_SRC: begin
        if (seed_go || level_seeded) begin
          div_req.start    = 1'b1;
          div_req.dividend = {cur_abs, 24'b0};
          div_req.divisor  = step_div;
          div_req.count    = DIV_CNT_W'(DIVIDEND_W);
          state_next       = S_STEP;
        end else begin
          state_next = S_UPD;
        end
      end
      S_STEP: begin
        if (!div_busy) state_next = S_UPD;
      end
      S_UPD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---- sample state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      error_run       <= '0;
      external_votes  <= '0;
      nobattery_votes <= '0;
      source_reg      <= SRC_UNKNOWN;
      level_fixed     <= '0;
      level_seeded    <= 1'b0;
      cutoff_reg      <= 1'b0;
      available_reg   <= 1'b0;
      voltage_reg     <= '0;
      current_reg     <= '0;
      percent_reg     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (read_error) begin
              error_run <= error_run_inc;
              if (error_run_inc >= ERR_MAX) available_reg <= 1'b0;
            end else begin
              error_run   <= '0;
              voltage_reg <= v_in;
              current_reg <= cur_in;
            end
          end
        end
        S_SRC: begin
          source_reg <= src_next;
          if (is_charging || is_discharging) begin
            external_votes  <= '0;
            nobattery_votes <= '0;
          end else begin
            external_votes  <= ext_next;
            nobattery_votes <= nob_next;
          end
          if (seed_go) begin
            level_fixed  <= {seed_pct, 24'b0};
            level_seeded <= 1'b1;
          end
        end
        S_STEP: begin
          if (!div_busy) begin
            level_fixed <= lvl_clamped;
            percent_reg <= lvl_round[LEVEL_W-1:PCT_FRAC];
          end
        end
        S_UPD: begin
          available_reg <= 1'b1;
          if (!cfg.protect_enable) begin
            cutoff_reg <= 1'b0;
          end else if (level_seeded && source_reg != SRC_NOBAT) begin
            if (!cutoff_reg && source_reg == SRC_CHARGING &&
                level_fixed >= {cfg.cut_percent, 24'b0} &&
                voltage_reg >= {3'b000, cfg.cut_min_mv}) begin
              cutoff_reg <= 1'b1;
            end else if (cutoff_reg && level_fixed <= {cfg.resume_percent, 24'b0}) begin
              cutoff_reg <= 1'b0;
            end
          end
        end
        S_EMIT: ;
        default: ;
      endcase
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      meas_mv          <= voltage_reg;
      meas_ma          <= current_reg;
      power_source     <= source_reg;
      level_percent    <= percent_reg;
      level_known      <= level_seeded;
      cutoff_active    <= cutoff_reg;
      charger_enable   <= !cutoff_reg;
      sensor_available <= available_reg;
    end
  end

endmodule
`default_nettype wire
